### hw/rtl/mcrr_pkg.sv
package mcrr_pkg;

  localparam int MAX_MOTORS = 8;
  localparam int IDX_W      = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
  localparam int CNT_W      = $clog2(MAX_MOTORS + 1);

  localparam logic [7:0] TICK_SAT          = 8'd255;
  localparam logic [3:0] RESET_ENGINE_CNT  = 4'd6;
  localparam logic [7:0] RESET_HOLD_TICKS  = 8'd4;

  // register indexes on the configuration port
  localparam logic REG_ENGINE_COUNT = 1'b0;
  localparam logic REG_REVERSE_HOLD = 1'b1;

  // request and command codes
  localparam logic REQ_SET_TARGET = 1'b0;
  localparam logic REQ_TICK       = 1'b1;
  localparam logic CMD_SPEED      = 1'b0;
  localparam logic CMD_REVERSE    = 1'b1;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic             exec_tick;
    logic             exec_set;
    logic [2:0]       motor_index;
    logic [7:0]       speed;
    logic             reverse;
    logic [CNT_W-1:0] motors;
    logic [7:0]       hold;
  } ctl_t;

  // command raised by the cell that is served
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] value;
  } res_t;

endpackage

### hw/rtl/motor_command_round_robin.sv
// a request accepted into the single request register is executed once the output register
// is free or being emptied; its command (if any) is then presented in the output register
// a new request is not accepted until the held one has been executed; a command left
// waiting on out_ready holds back the next execution
// reset (rst_n low, synchronous): all motor state zero, pointer token on motor 0,
// engine_count 6, reverse_hold_ticks 4, no request or command pending
module motor_command_round_robin (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [2:0] in_motor_index,
  input  logic [7:0] in_target_speed,
  input  logic       in_target_reverse,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_cmd_kind,
  output logic [2:0] out_cmd_motor,
  output logic [7:0] out_cmd_value,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int N = mcrr_pkg::MAX_MOTORS;

  logic [3:0] engine_count_r;
  logic [7:0] hold_r;

  logic       busy_r;
  logic       req_type_r;
  logic [2:0] req_motor_r;
  logic [7:0] req_speed_r;
  logic       req_rev_r;

  logic       out_valid_r;
  logic       out_kind_r;
  logic [2:0] out_motor_r;
  logic [7:0] out_value_r;

  logic                       exec_en;
  logic [mcrr_pkg::CNT_W-1:0] motors;
  mcrr_pkg::ctl_t             ctl;
  logic [N-1:0]               tok;
  logic [N-1:0]               tok_in;
  logic [N-1:0]               wrap_req;
  logic [N-1:0]               res_valid;
  mcrr_pkg::res_t             res [N];

  logic       any_valid;
  logic       sel_kind;
  logic [2:0] sel_motor;
  logic [7:0] sel_value;

  always_comb begin
    if (engine_count_r == 4'd0) begin
      motors = mcrr_pkg::CNT_W'(1);
    end else if (32'(engine_count_r) > N) begin
      motors = mcrr_pkg::CNT_W'(N);
    end else begin
      motors = mcrr_pkg::CNT_W'(engine_count_r);
    end
  end

  // execute only when the output slot is free or being emptied
  assign exec_en  = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r;

  always_comb begin
    ctl.exec_tick   = exec_en && (req_type_r == mcrr_pkg::REQ_TICK);
    ctl.exec_set    = exec_en && (req_type_r == mcrr_pkg::REQ_SET_TARGET);
    ctl.motor_index = req_motor_r;
    ctl.speed       = req_speed_r;
    ctl.reverse     = req_rev_r;
    ctl.motors      = motors;
    ctl.hold        = hold_r;
  end

  // token ring: cell 0 picks up the token when its holder wraps
  always_comb begin
    tok_in[0] = |wrap_req;
    for (int i = 1; i < N; i++) begin
      tok_in[i] = tok[i-1];
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    mcrr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (mcrr_pkg::IDX_W'(g)),
      .ctl      (ctl),
      .tok_in   (tok_in[g]),
      .tok_out  (tok[g]),
      .wrap_req (wrap_req[g]),
      .res      (res[g])
    );
    assign res_valid[g] = res[g].valid;
  end

  // at most one cell raises a command, so the results are merged by or
  always_comb begin
    any_valid = 1'b0;
    sel_kind  = 1'b0;
    sel_motor = '0;
    sel_value = '0;
    for (int i = 0; i < N; i++) begin
      if (res[i].valid) begin
        any_valid = 1'b1;
        sel_kind  = sel_kind | res[i].kind;
        sel_motor = sel_motor | 3'(i);
        sel_value = sel_value | res[i].value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engine_count_r <= mcrr_pkg::RESET_ENGINE_CNT;
      hold_r         <= mcrr_pkg::RESET_HOLD_TICKS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mcrr_pkg::REG_ENGINE_COUNT: engine_count_r <= cfg_data[3:0];
        mcrr_pkg::REG_REVERSE_HOLD: hold_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy_r <= 1'b1;
    end else if (exec_en) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_type_r  <= in_req_type;
      req_motor_r <= in_motor_index;
      req_speed_r <= in_target_speed;
      req_rev_r   <= in_target_reverse;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_en) begin
      out_valid_r <= any_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en && any_valid) begin
      out_kind_r  <= sel_kind;
      out_motor_r <= sel_motor;
      out_value_r <= sel_value;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cmd_kind  = out_kind_r;
  assign out_cmd_motor = out_motor_r;
  assign out_cmd_value = out_value_r;

  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(tok))
    else $error("round-robin token not one-hot");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(res_valid))
    else $error("more than one cell raised a command");

  a_cmd_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(exec_en))
    else $error("command appeared without an executed request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> busy_r)
    else $error("accepted request not held");

endmodule

### hw/rtl/mcrr_cell.sv
module mcrr_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mcrr_pkg::IDX_W-1:0] cell_idx,
  input  mcrr_pkg::ctl_t             ctl,
  input  logic                       tok_in,
  output logic                       tok_out,
  output logic                       wrap_req,
  output mcrr_pkg::res_t             res
);

  logic [7:0] des_speed_r, des_speed_nxt;
  logic [7:0] app_speed_r, app_speed_nxt;
  logic       des_dir_r, des_dir_nxt;
  logic       app_dir_r, app_dir_nxt;
  logic [7:0] ticks_r, ticks_nxt;
  logic       tok_r, tok_nxt;

  logic                       in_use;
  logic                       take;
  logic [7:0]                 ticks_inc;
  logic                       do_rev;
  logic                       do_speed;
  logic [mcrr_pkg::CNT_W-1:0] idx_ext;

  assign idx_ext  = mcrr_pkg::CNT_W'(cell_idx);
  assign in_use   = idx_ext < ctl.motors;
  // the pointer wraps when the next motor is not in use (also for a stale pointer)
  assign wrap_req = tok_r && ((idx_ext + mcrr_pkg::CNT_W'(1)) >= ctl.motors);
  assign take     = tok_in && in_use;
  assign tok_out  = tok_r;

  always_comb begin
    ticks_inc = ticks_r;
    if (ctl.exec_tick && in_use && (ticks_r != mcrr_pkg::TICK_SAT)) begin
      ticks_inc = ticks_r + 8'd1;
    end
  end

  assign do_rev   = ctl.exec_tick && take && (ticks_inc >= ctl.hold) && (des_dir_r != app_dir_r);
  assign do_speed = ctl.exec_tick && take && !do_rev && (des_speed_r != app_speed_r);

  always_comb begin
    des_speed_nxt = des_speed_r;
    des_dir_nxt   = des_dir_r;
    app_speed_nxt = app_speed_r;
    app_dir_nxt   = app_dir_r;
    ticks_nxt     = ticks_inc;
    tok_nxt       = tok_r;
    if (ctl.exec_set && (8'(ctl.motor_index) == 8'(cell_idx))) begin
      des_speed_nxt = ctl.speed;
      des_dir_nxt   = ctl.reverse;
    end
    if (ctl.exec_tick) begin
      tok_nxt = take;
    end
    if (do_rev) begin
      app_dir_nxt = des_dir_r;
      ticks_nxt   = 8'd0;
    end
    if (do_speed) begin
      app_speed_nxt = des_speed_r;
    end
  end

  always_comb begin
    res.valid = do_rev || do_speed;
    res.kind  = do_rev ? mcrr_pkg::CMD_REVERSE : mcrr_pkg::CMD_SPEED;
    res.value = do_rev ? {7'd0, des_dir_r} : des_speed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      des_speed_r <= '0;
      app_speed_r <= '0;
      des_dir_r   <= 1'b0;
      app_dir_r   <= 1'b0;
      ticks_r     <= '0;
      tok_r       <= (cell_idx == '0);
    end else begin
      des_speed_r <= des_speed_nxt;
      app_speed_r <= app_speed_nxt;
      des_dir_r   <= des_dir_nxt;
      app_dir_r   <= app_dir_nxt;
      ticks_r     <= ticks_nxt;
      tok_r       <= tok_nxt;
    end
  end

endmodule
